/* hw/rtl/dfht_pkg.sv */
// Package for the depth frame history taps block.
// Holds field widths, reset values, register indexes and the sequencer state type.
// No dependencies.
package dfht_pkg;

  // Field and register widths
  localparam int DEPTH_W       = 16;
  localparam int NORM_W        = 16;
  localparam int INV_W         = 33;
  localparam int PROD_W        = DEPTH_W + INV_W;
  localparam int FRAME_LEN_W   = 11;
  localparam int AGE_W         = 6;
  localparam int TAP_AGES_W    = 48;
  localparam int TAP_IDX_W     = 3;
  localparam int PIX_IDX_W     = 10;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 5;
  localparam int OUT_TDATA_W   = 32;

  // Saturation limit of the frames-seen counter
  localparam logic [AGE_W-1:0] FRAMES_SEEN_MAX = 6'd63;

  // Register reset values
  localparam logic [INV_W-1:0]       INV_RANGE_RST    = 33'd1717987;
  localparam logic [FRAME_LEN_W-1:0] FRAME_PIXELS_RST = 11'd576;
  localparam logic [TAP_AGES_W-1:0]  TAP_AGES_RST     = 48'd354591807395;

  // Register indexes, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_MIN_DEPTH    = 2'd0,
    REG_INV_RANGE    = 2'd1,
    REG_FRAME_PIXELS = 2'd2,
    REG_TAP_AGES     = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_MUL   = 2'd1,
    S_WRITE = 2'd2,
    S_TAPS  = 2'd3
  } seq_state_t;

endpackage

/* hw/rtl/dfht_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Read data holds while the read enable is low. No dependencies.
module dfht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/dfht_norm.sv */
// Depth normaliser: offset removal, reciprocal scaling and saturation to Q0.16.
// Depends on dfht_pkg.
module dfht_norm (
  input  logic                          clk,
  input  logic                          load_en,
  input  logic                          mul_en,
  input  logic [dfht_pkg::DEPTH_W-1:0]  sample_mm,
  input  logic [dfht_pkg::DEPTH_W-1:0]  floor_mm,
  input  logic [dfht_pkg::INV_W-1:0]    inverse_range,
  output logic [dfht_pkg::NORM_W-1:0]   norm_value
);

  import dfht_pkg::*;

  logic [DEPTH_W-1:0] diff_r;
  logic [DEPTH_W-1:0] diff_nxt;
  logic [PROD_W-1:0]  prod_r;

  // Distance above the minimum, clamped below at zero
  assign diff_nxt = (sample_mm > floor_mm) ? (sample_mm - floor_mm) : '0;

  always_ff @(posedge clk) begin
    if (load_en) begin
      diff_r <= diff_nxt;
    end
  end

  // Scaling multiply, registered
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_W'(diff_r) * PROD_W'(inverse_range);
    end
  end

  // Drop sixteen fraction bits and saturate at full scale
  assign norm_value = (|prod_r[PROD_W-1:2*NORM_W]) ? {NORM_W{1'b1}}
                                                    : prod_r[2*NORM_W-1:NORM_W];

endmodule

/* hw/rtl/depth_frame_history_taps_top.sv */
// Depth frame history taps: each accepted sample yields TAP_COUNT results.
// A new sample is taken only after the last tap of the previous one has moved
// to the output register; the taps are read one per cycle, while the output
// does not stall, through the single read port of the history RAM.
// Reset (rst_n, synchronous) clears the sequencer, counters, sets registers
// to reset values; the history RAM is not cleared and needs no clearing pass.
module depth_frame_history_taps_top #(
  parameter int HISTORY_FRAMES = 64,
  parameter int MAX_PIXELS     = 1024,
  parameter int TAP_COUNT      = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [15:0] depth sample in mm
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] tap_index, [12:3] pixel_index, [28:13] norm_value, [31:29] zero
  output logic [dfht_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,  // last_of_run
  output logic                              out_tuser,  // [0] frame_end
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dfht_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [dfht_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [dfht_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  import dfht_pkg::*;

  localparam int SLOT_W  = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
  localparam int PIX_W   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int LEN_W   = ($clog2(MAX_PIXELS + 1) > FRAME_LEN_W) ?
                           $clog2(MAX_PIXELS + 1) : FRAME_LEN_W;
  localparam int TAP_W   = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int ADDR_W  = SLOT_W + PIX_W;
  localparam int RAM_DEPTH = HISTORY_FRAMES * (2 ** PIX_W);

  // Configuration registers
  logic [DEPTH_W-1:0]     min_depth_r;
  logic [INV_W-1:0]       inv_range_r;
  logic [FRAME_LEN_W-1:0] frame_pixels_r;
  logic [TAP_AGES_W-1:0]  tap_ages_r;
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  // Sequencer and history state
  seq_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [PIX_W-1:0]  pixel_cnt_r, pixel_cnt_nxt;
  logic [AGE_W-1:0]  frames_seen_r, frames_seen_nxt;

  // Per-sample context
  logic [SLOT_W-1:0] item_slot_r;
  logic [PIX_W-1:0]  item_pix_r;
  logic              item_last_r;
  logic [SLOT_W-1:0] item_max_age_r;
  logic [SLOT_W-1:0] max_age_nxt;

  // Tap read sequencing
  logic [TAP_W-1:0]  issue_tap_r;
  logic              issue_more_r;
  logic [TAP_W-1:0]  rd_tap_r;
  logic              rd_pend_r;
  logic              can_load;
  logic              issue;
  logic              issue_last;

  // Sequencer outputs
  logic in_accept;
  logic norm_load;
  logic mul_en;
  logic ram_we;
  logic taps_start;

  // Frame length and end-of-frame decision
  logic [LEN_W-1:0]  frame_len;
  logic              last_pixel;

  // Address generation
  logic [AGE_W-1:0]  tap_age;
  logic [SLOT_W-1:0] age_clamped;
  logic [SLOT_W:0]   src_diff;
  logic [SLOT_W-1:0] src_slot;

  // Datapath
  logic [NORM_W-1:0] norm_value;
  logic [NORM_W-1:0] ram_rdata;

  // Output register
  logic                 out_valid_r;
  logic [TAP_IDX_W-1:0] out_tap_r;
  logic [PIX_IDX_W-1:0] out_pix_r;
  logic [NORM_W-1:0]    out_norm_r;
  logic                 out_last_r;
  logic                 out_fend_r;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r    <= '0;
      inv_range_r    <= INV_RANGE_RST;
      frame_pixels_r <= FRAME_PIXELS_RST;
      tap_ages_r     <= TAP_AGES_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_DEPTH:    min_depth_r    <= cfg_pwdata[DEPTH_W-1:0];
        REG_INV_RANGE:    inv_range_r    <= cfg_pwdata[INV_W-1:0];
        REG_FRAME_PIXELS: frame_pixels_r <= cfg_pwdata[FRAME_LEN_W-1:0];
        REG_TAP_AGES:     tap_ages_r     <= cfg_pwdata[TAP_AGES_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_MIN_DEPTH:    cfg_prdata = CFG_DATA_W'(min_depth_r);
      REG_INV_RANGE:    cfg_prdata = CFG_DATA_W'(inv_range_r);
      REG_FRAME_PIXELS: cfg_prdata = CFG_DATA_W'(frame_pixels_r);
      REG_TAP_AGES:     cfg_prdata = CFG_DATA_W'(tap_ages_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  // A tap result moves from the RAM read register to the output register
  // when the output register is empty or being drained.
  assign can_load   = rd_pend_r & (~out_valid_r | out_tready);
  assign issue      = (state_r == S_TAPS) & issue_more_r & (~rd_pend_r | can_load);
  assign issue_last = issue_tap_r == TAP_W'(TAP_COUNT - 1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_TAPS;
      S_TAPS:  if (~issue_more_r & can_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready  = 1'b0;
    norm_load  = 1'b0;
    mul_en     = 1'b0;
    ram_we     = 1'b0;
    taps_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        norm_load = 1'b1;
      end
      S_MUL:   mul_en = 1'b1;
      S_WRITE: begin
        ram_we     = 1'b1;
        taps_start = 1'b1;
      end
      S_TAPS:  ;
      default: ;
    endcase
  end

  assign in_accept = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Frame position counters
  // ---------------------------------------------------------------------
  // Frame length register of zero acts as one; above the maximum it clamps.
  always_comb begin
    if (frame_pixels_r == '0) begin
      frame_len = LEN_W'(1);
    end else if (LEN_W'(frame_pixels_r) > LEN_W'(MAX_PIXELS)) begin
      frame_len = LEN_W'(MAX_PIXELS);
    end else begin
      frame_len = LEN_W'(frame_pixels_r);
    end
  end

  assign last_pixel  = (LEN_W'(pixel_cnt_r) + LEN_W'(1)) >= frame_len;
  assign max_age_nxt = (frames_seen_r > AGE_W'(HISTORY_FRAMES - 1)) ?
                       SLOT_W'(HISTORY_FRAMES - 1) : SLOT_W'(frames_seen_r);

  always_comb begin
    pixel_cnt_nxt   = pixel_cnt_r;
    write_slot_nxt  = write_slot_r;
    frames_seen_nxt = frames_seen_r;
    if (in_accept) begin
      if (last_pixel) begin
        pixel_cnt_nxt  = '0;
        write_slot_nxt = (write_slot_r == SLOT_W'(HISTORY_FRAMES - 1)) ?
                         '0 : write_slot_r + SLOT_W'(1);
        if (frames_seen_r != FRAMES_SEEN_MAX) begin
          frames_seen_nxt = frames_seen_r + AGE_W'(1);
        end
      end else begin
        pixel_cnt_nxt = pixel_cnt_r + PIX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_cnt_r   <= '0;
      write_slot_r  <= '0;
      frames_seen_r <= '0;
    end else begin
      pixel_cnt_r   <= pixel_cnt_nxt;
      write_slot_r  <= write_slot_nxt;
      frames_seen_r <= frames_seen_nxt;
    end
  end

  // Context of the sample in flight, captured at its transfer
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_slot_r    <= write_slot_r;
      item_pix_r     <= pixel_cnt_r;
      item_last_r    <= last_pixel;
      item_max_age_r <= max_age_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Normaliser
  // ---------------------------------------------------------------------
  dfht_norm u_norm (
    .clk           (clk),
    .load_en       (norm_load),
    .mul_en        (mul_en),
    .sample_mm     (in_tdata[DEPTH_W-1:0]),
    .floor_mm      (min_depth_r),
    .inverse_range (inv_range_r),
    .norm_value    (norm_value)
  );

  // ---------------------------------------------------------------------
  // Tap address unit: while the output does not stall, one tap per cycle
  // ---------------------------------------------------------------------
  assign tap_age     = tap_ages_r[int'(issue_tap_r) * AGE_W +: AGE_W];
  assign age_clamped = (tap_age > AGE_W'(item_max_age_r)) ? item_max_age_r
                                                          : SLOT_W'(tap_age);
  assign src_diff    = {1'b0, item_slot_r} - {1'b0, age_clamped};
  // Wrap round the ring of frames when the age reaches past slot zero
  assign src_slot    = src_diff[SLOT_W] ? SLOT_W'(src_diff + (SLOT_W + 1)'(HISTORY_FRAMES))
                                        : src_diff[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_more_r <= 1'b0;
      issue_tap_r  <= '0;
      rd_pend_r    <= 1'b0;
    end else begin
      if (taps_start) begin
        issue_more_r <= 1'b1;
        issue_tap_r  <= '0;
      end else if (issue) begin
        issue_more_r <= ~issue_last;
        issue_tap_r  <= issue_last ? '0 : issue_tap_r + TAP_W'(1);
      end
      rd_pend_r <= issue | (rd_pend_r & ~can_load);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_tap_r <= issue_tap_r;
    end
  end

  // ---------------------------------------------------------------------
  // History RAM
  // ---------------------------------------------------------------------
  dfht_ram #(
    .WIDTH (NORM_W),
    .DEPTH (RAM_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'({item_slot_r, item_pix_r})),
    .wdata (norm_value),
    .re    (issue),
    .raddr (ADDR_W'({src_slot, item_pix_r})),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= can_load | (out_valid_r & ~out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      out_tap_r  <= TAP_IDX_W'(rd_tap_r);
      out_pix_r  <= PIX_IDX_W'(item_pix_r);
      out_norm_r <= ram_rdata;
      out_last_r <= rd_tap_r == TAP_W'(TAP_COUNT - 1);
      out_fend_r <= item_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_norm_r, out_pix_r, out_tap_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_fend_r;

endmodule

/* hw/rtl/dfht_checker.sv */
// Port-level checker for the depth frame history taps block, and its bind.
// Depends on dfht_pkg and on depth_frame_history_taps_top.
module dfht_checker #(
  parameter int TAP_COUNT = 8
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dfht_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);

  import dfht_pkg::*;

  // After reset the block is ready for input and shows no result.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // A sample transfer keeps the input closed in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still open after a sample transfer");

  // The last result of a run is exactly the one of the highest tap.
  a_last_on_final_tap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[2:0] == 3'(TAP_COUNT - 1))))
    else $error("tlast does not match the final tap");

  // Results of one run all carry the same pixel index.
  a_run_same_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      !out_tvalid || (out_tdata[12:3] == $past(out_tdata[12:3])))
    else $error("pixel index changed within a run");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind depth_frame_history_taps_top dfht_checker #(
  .TAP_COUNT (TAP_COUNT)
) u_dfht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* tb/sv/depth_frame_history_taps_top_tb.sv */
// Self-checking testbench for depth_frame_history_taps_top.
// Depends on dfht_pkg and the top level only; a built-in predictor of the
// normalisation and the history gives every expected result not typed in.
module depth_frame_history_taps_top_tb;
  import dfht_pkg::*;

  localparam int HIST_FRAMES = 64;
  localparam int MAX_PIX     = 1024;
  localparam int TAPS        = 8;
  localparam int QUIET_LIMIT = 2000;

  // One expected tap result, fields as they travel on the result stream.
  typedef struct packed {
    logic [TAP_IDX_W-1:0] tap;
    logic [PIX_IDX_W-1:0] pix;
    logic [NORM_W-1:0]    norm;
    logic                 last;
    logic                 fend;
  } tap_result_t;

  // One row of the directed table: a register write or a depth sample.
  typedef struct packed {
    logic                  is_cfg;
    reg_idx_t              sel;
    logic [CFG_DATA_W-1:0] value;
    logic [DEPTH_W-1:0]    depth;
    logic                  fixed;
    logic [NORM_W-1:0]     norm_fix;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Shadow copy of the registers.
  logic [DEPTH_W-1:0]     min_mm = '0;
  logic [INV_W-1:0]       inv_range = INV_RANGE_RST;
  logic [FRAME_LEN_W-1:0] frame_len_cfg = FRAME_PIXELS_RST;
  logic [TAP_AGES_W-1:0]  tap_age_cfg = TAP_AGES_RST;

  // Predicted history of normalised samples and the frame bookkeeping.
  logic [NORM_W-1:0] ring_mem [HIST_FRAMES*MAX_PIX];
  int                slot_wr = 0;
  int                pix_pos = 0;
  int                frames_done = 0;
  int                shortest_frame = MAX_PIX;

  tap_result_t due_taps [$];
  stim_row_t   plan [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          allow_gaps = 1'b1;
  bit          tail_phase = 1'b0;

  depth_frame_history_taps_top #(
    .HISTORY_FRAMES (HIST_FRAMES),
    .MAX_PIXELS     (MAX_PIX),
    .TAP_COUNT      (TAPS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Subtract the minimum, clamp at zero, scale and saturate to Q0.16.
  function automatic logic [NORM_W-1:0] scale_depth(input logic [DEPTH_W-1:0] d);
    logic [DEPTH_W-1:0] over;
    logic [PROD_W-1:0]  prod;
    over = (d > min_mm) ? d - min_mm : '0;
    prod = over * inv_range;
    if (prod[PROD_W-1:16] > 65535) return 16'hFFFF;
    return prod[31:16];
  endfunction

  // Store the sample, queue one result per tap and advance the frame position.
  task automatic taps_for_sample(input logic [DEPTH_W-1:0] d, input logic fixed,
                                 input logic [NORM_W-1:0] norm_fix);
    int          eff_len;
    int          age;
    int          src;
    bit          ends;
    tap_result_t r;
    eff_len = (frame_len_cfg == 0) ? 1 : ((frame_len_cfg > MAX_PIX) ? MAX_PIX : frame_len_cfg);
    ends = (pix_pos + 1) >= eff_len;
    ring_mem[slot_wr*MAX_PIX + pix_pos] = scale_depth(d);
    for (int t = 0; t < TAPS; t++) begin
      age = tap_age_cfg[6*t +: AGE_W];
      if (age > frames_done) age = frames_done;
      src = (slot_wr + HIST_FRAMES - age) % HIST_FRAMES;
      r.tap  = t;
      r.pix  = pix_pos;
      r.norm = fixed ? norm_fix : ring_mem[src*MAX_PIX + pix_pos];
      r.last = (t == TAPS - 1);
      r.fend = ends;
      due_taps.insert(due_taps.size(), r);
    end
    if (ends) begin
      if (pix_pos + 1 < shortest_frame) shortest_frame = pix_pos + 1;
      pix_pos = 0;
      slot_wr = (slot_wr + 1) % HIST_FRAMES;
      if (frames_done < FRAMES_SEEN_MAX) frames_done++;
    end else begin
      pix_pos++;
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  // One register write: setup then access; psel is left high for a following write.
  task automatic write_reg(input reg_idx_t sel, input logic [CFG_DATA_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 3'b000};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (sel)
      REG_MIN_DEPTH:    min_mm = v[DEPTH_W-1:0];
      REG_INV_RANGE:    inv_range = v[INV_W-1:0];
      REG_FRAME_PIXELS: frame_len_cfg = v[FRAME_LEN_W-1:0];
      REG_TAP_AGES:     tap_age_cfg = v[TAP_AGES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic bus_idle();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Drop the stream and let every expected result come out.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (due_taps.size() != 0) @(posedge clk);
  endtask

  // Offer one sample until it is taken, then maybe leave a gap.
  task automatic push_sample(input logic [DEPTH_W-1:0] d, input logic fixed,
                             input logic [NORM_W-1:0] norm_fix);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    taps_for_sample(d, fixed, norm_fix);
    if (allow_gaps && !tail_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic void add_write(input reg_idx_t sel, input logic [CFG_DATA_W-1:0] v);
    stim_row_t row;
    row = {1'b1, sel, v, 16'h0, 1'b0, 16'h0};
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_sample(input logic [DEPTH_W-1:0] d, input logic fixed,
                                     input logic [NORM_W-1:0] norm_fix);
    stim_row_t row;
    row = {1'b0, REG_MIN_DEPTH, 64'h0, d, fixed, norm_fix};
    plan.insert(plan.size(), row);
  endfunction

  // Result side stalls in random bursts while gaps are allowed outside the tail phase.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (allow_gaps && !tail_phase && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    tap_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_taps.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected, tdata %h", out_tdata));
      end else begin
        want = due_taps[0];
        due_taps.delete(0);
        if (out_tdata[2:0] !== want.tap)
          note_mismatch($sformatf("tap_index %0d, expected %0d", out_tdata[2:0], want.tap));
        if (out_tdata[12:3] !== want.pix)
          note_mismatch($sformatf("tap %0d pixel_index %0d, expected %0d",
                                  want.tap, out_tdata[12:3], want.pix));
        if (out_tdata[28:13] !== want.norm)
          note_mismatch($sformatf("tap %0d pixel %0d norm_value %0d, expected %0d",
                                  want.tap, want.pix, out_tdata[28:13], want.norm));
        if (out_tlast !== want.last)
          note_mismatch($sformatf("tap %0d pixel %0d last_of_run %b, expected %b",
                                  want.tap, want.pix, out_tlast, want.last));
        if (out_tuser !== want.fend)
          note_mismatch($sformatf("tap %0d pixel %0d frame_end %b, expected %b",
                                  want.tap, want.pix, out_tuser, want.fend));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] min_pick;
    logic [CFG_DATA_W-1:0] inv_pick;
    logic [CFG_DATA_W-1:0] len_pick;
    logic [CFG_DATA_W-1:0] ages_pick;
    bit                    short_ages;
    bit                    apb_held;
    int                    n_items;
    int                    d;

    // Directed table. In the first frame every tap reads the sample just
    // written, so the normalised values there are typed in.
    add_write(REG_FRAME_PIXELS, 64'd2047);            // above the maximum: 1024
    add_sample(16'd0, 1'b1, 16'd0);                   // hole
    add_sample(16'd65535, 1'b1, 16'd65535);           // saturates
    add_sample(16'd1, 1'b1, 16'd26);
    add_sample(16'd2499, 1'b1, 16'd65509);
    add_sample(16'd2500, 1'b1, 16'd65535);            // just over full scale
    add_write(REG_MIN_DEPTH, 64'd1000);
    add_write(REG_INV_RANGE, 64'h1_0000_0000);
    add_sample(16'd999, 1'b1, 16'd0);                 // below the minimum
    add_sample(16'd1000, 1'b1, 16'd0);
    add_sample(16'd1001, 1'b1, 16'd65535);
    add_write(REG_MIN_DEPTH, 64'd65535);
    add_sample(16'd65535, 1'b1, 16'd0);
    add_sample(16'd65534, 1'b1, 16'd0);
    add_write(REG_MIN_DEPTH, 64'd0);
    add_write(REG_INV_RANGE, 64'd0);
    add_sample(16'd40000, 1'b1, 16'd0);
    add_write(REG_INV_RANGE, 64'd65536);              // unity scale
    add_sample(16'hA5A5, 1'b1, 16'hA5A5);
    add_sample(16'h5A5A, 1'b1, 16'h5A5A);
    // Shrinking the frame below the current position ends the frame at once.
    add_write(REG_FRAME_PIXELS, 64'd7);
    add_sample(16'd1234, 1'b1, 16'd1234);
    // Ages out of order and beyond the history seen so far.
    add_write(REG_TAP_AGES, {16'h0, 6'd3, 6'd0, 6'd7, 6'd2, 6'd40, 6'd1, 6'd63, 6'd0});
    for (int i = 0; i < 6; i++) add_sample(16'd300 * (i + 1), 1'b0, 16'h0);
    add_write(REG_TAP_AGES, 64'hFFFF_FFFF_FFFF);
    add_sample(16'd4321, 1'b0, 16'h0);
    add_sample(16'd8765, 1'b0, 16'h0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    apb_held = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].sel, plan[i].value);
        apb_held = 1'b1;
      end else begin
        if (apb_held) bus_idle();
        apb_held = 1'b0;
        push_sample(plan[i].depth, plan[i].fixed, plan[i].norm_fix);
      end
    end

    // Random phases. The frame length never exceeds the shortest frame
    // completed so far, so no tap reads a history entry never written.
    // The last phase uses one-sample frames to fill and wrap the history.
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      tail_phase = (phase == 5);
      allow_gaps = ($urandom_range(0, 3) != 0);
      min_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 3000);
      if ($urandom_range(0, 4) == 0)
        inv_pick = {1'($urandom_range(0, 1)), $urandom};
      else
        inv_pick = $urandom_range(20000, 400000);
      if (tail_phase)
        len_pick = 0;
      else if ($urandom_range(0, 1) == 1)
        len_pick = shortest_frame;
      else
        len_pick = $urandom_range(1, shortest_frame);
      short_ages = ($urandom_range(0, 1) == 1);
      ages_pick = '0;
      for (int t = 0; t < TAPS; t++)
        ages_pick[6*t +: AGE_W] = short_ages ? 6'($urandom_range(0, 6))
                                             : 6'($urandom_range(0, 63));
      write_reg(REG_MIN_DEPTH, min_pick);
      write_reg(REG_INV_RANGE, inv_pick);
      write_reg(REG_FRAME_PIXELS, len_pick);
      write_reg(REG_TAP_AGES, ages_pick);
      bus_idle();

      n_items = tail_phase ? 70 : $urandom_range(18, 26);
      repeat (n_items) begin
        case ($urandom_range(0, 7))
          0:       d = 0;
          1, 2:    d = $urandom_range(0, 65535);
          default: d = min_mm + $urandom_range(0, 8000);
        endcase
        if (d > 65535) d = 65535;
        push_sample(16'(d), 1'b0, 16'h0);
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
